// ===== rtl/slcw_pkg.sv =====
// ----------------------------------------------------------------------------
// slcw_pkg: shared types and constants of the serial lcd command writer
// Word formats, command codes, sync bytes and the instruction tables.
// ----------------------------------------------------------------------------
package slcw_pkg;

	localparam int FRAME_BITS = 24;
	localparam int BIT_CNT_W  = 5;

	// command codes
	localparam logic [2:0] CMD_WRITE_CHAR = 3'd0;
	localparam logic [2:0] CMD_SET_ROW    = 3'd1;
	localparam logic [2:0] CMD_DISP_MODE  = 3'd2;
	localparam logic [2:0] CMD_CLEAR_ALL  = 3'd3;
	localparam logic [2:0] CMD_EFFECT     = 3'd4;
	localparam logic [2:0] CMD_RAW_INSTR  = 3'd5;

	// effect codes
	localparam logic [7:0] EFF_SHIFT_RIGHT = 8'd0;
	localparam logic [7:0] EFF_SHIFT_LEFT  = 8'd1;
	localparam logic [7:0] EFF_HIGHLIGHT   = 8'd2;

	// sync bytes and fixed instructions
	localparam logic [7:0] SYNC_INSTR   = 8'hF8;
	localparam logic [7:0] SYNC_DATA    = 8'hFA;
	localparam logic [7:0] INSTR_CLEAR  = 8'h01;
	localparam logic [7:0] INSTR_SHR    = 8'h1C;
	localparam logic [7:0] INSTR_SHL    = 8'h18;
	localparam logic [7:0] INSTR_HOME   = 8'h80;
	localparam logic [7:0] INSTR_HILITE = 8'h0D;
	localparam logic [7:0] MODE_MAX     = 8'd4;

	typedef struct packed {
		logic [2:0] command;
		logic [7:0] value;
	} cmd_word_t;

	typedef struct packed {
		logic sid_bit;
		logic frame_end;
		logic last;
	} ser_word_t;

	// one frame to be shifted out
	typedef struct packed {
		logic       is_data;
		logic [7:0] payload;
		logic       last;
	} frame_job_t;

	function automatic logic [7:0] row_addr(input logic [1:0] row);
		logic [7:0] a;
		case (row)
			2'd0:    a = 8'h80;
			2'd1:    a = 8'h90;
			2'd2:    a = 8'h88;
			default: a = 8'h98;
		endcase
		return a;
	endfunction

	function automatic logic [7:0] mode_code(input logic [2:0] mode);
		logic [7:0] c;
		case (mode)
			3'd0:    c = 8'h08;
			3'd1:    c = 8'h0C;
			3'd2:    c = 8'h0E;
			3'd3:    c = 8'h0D;
			default: c = 8'h0F;
		endcase
		return c;
	endfunction

endpackage

// ===== rtl/serial_lcd_command_writer_top.sv =====
// ----------------------------------------------------------------------------
// serial_lcd_command_writer_top: serial command writer for a character lcd
// Turns lcd commands into 24-bit serial frames (sync byte, high nibble,
// low nibble), tracks the cursor row and column and inserts row address
// frames when a row fills up.
// ----------------------------------------------------------------------------
//  channel   dir  handshake            word
//  cmd       in   cmd_valid/cmd_stall  cmd_word_t {command, value}
//  ser       out  ser_valid/ser_stall  ser_word_t {sid_bit, frame_end, last}
//
//  one serial bit word per cycle while ser_stall is low and a frame is
//  loaded; a frame is 24 bit words, loaded from the queue before it shifts
//  a command costs 0, 24 or 48 bit words, set by its number of frames;
//  rejected values and unknown commands cost none, a character that closes
//  a row, and a highlight, cost two frames
//  the decoder runs ahead through a four-frame queue and only stalls the
//  command side when that queue is full or a second frame is still pending
//  arst_n clears cursor (row one, column zero), queue and serializer
// ----------------------------------------------------------------------------
module serial_lcd_command_writer_top #(
	parameter int CHARS_PER_ROW = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cmd_valid,
	output logic                 cmd_stall,
	input  slcw_pkg::cmd_word_t  cmd_word,
	output logic                 ser_valid,
	input  logic                 ser_stall,
	output slcw_pkg::ser_word_t  ser_word
);
	import slcw_pkg::*;

	// front to queue
	logic       push;
	frame_job_t push_job;
	logic       q_full;

	// queue to back
	logic       pop;
	frame_job_t pop_job;
	logic       q_empty;

	// decoder: cursor state lives here and is updated at accept time
	slcw_front #(
		.CHARS_PER_ROW (CHARS_PER_ROW)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd_word),
		.push      (push),
		.push_job  (push_job),
		.q_full    (q_full)
	);

	// frame jobs wait here so decode and shifting stall independently
	slcw_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.full     (q_full),
		.pop      (pop),
		.pop_job  (pop_job),
		.empty    (q_empty)
	);

	// serializer with registered output word
	slcw_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_job     (pop_job),
		.pop       (pop),
		.ser_valid (ser_valid),
		.ser_stall (ser_stall),
		.ser_word  (ser_word)
	);

endmodule

// ===== rtl/slcw_front.sv =====
// ----------------------------------------------------------------------------
// slcw_front: command decoder and cursor tracker
// Accepts command words, updates row and column, pushes frame jobs.
// ----------------------------------------------------------------------------
module slcw_front #(
	parameter int CHARS_PER_ROW = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cmd_valid,
	output logic                  cmd_stall,
	input  slcw_pkg::cmd_word_t   cmd,
	output logic                  push,
	output slcw_pkg::frame_job_t  push_job,
	input  logic                  q_full
);
	import slcw_pkg::*;

	localparam logic [4:0] CPR = 5'(CHARS_PER_ROW);

	logic [1:0]  row_q;
	logic [3:0]  col_q;
	logic        pend_q;
	logic [7:0]  pend_payload_q;

	logic        acc;
	logic        n_one;
	logic        n_two;
	logic [7:0]  pay1;
	logic [7:0]  pay2;
	logic        data1;
	logic        upd;
	logic [1:0]  row_d;
	logic [3:0]  col_d;
	logic [4:0]  col_inc;

	assign cmd_stall = pend_q | q_full;
	assign acc       = cmd_valid & ~cmd_stall;
	assign col_inc   = {1'b0, col_q} + 5'd1;

	always_comb begin
		n_one = 1'b0;
		n_two = 1'b0;
		pay1  = cmd.value;
		pay2  = INSTR_HILITE;
		data1 = 1'b0;
		upd   = 1'b0;
		row_d = row_q;
		col_d = col_q;
		case (cmd.command)
			CMD_WRITE_CHAR: begin
				n_one = 1'b1;
				data1 = 1'b1;
				upd   = 1'b1;
				if (col_inc >= CPR) begin
					n_two = 1'b1;
					row_d = row_q + 2'd1;
					col_d = 4'd0;
					pay2  = row_addr(row_q + 2'd1);
				end else begin
					col_d = col_inc[3:0];
				end
			end
			CMD_SET_ROW: begin
				if (cmd.value >= 8'd1 && cmd.value <= 8'd4) begin
					n_one = 1'b1;
					upd   = 1'b1;
					row_d = cmd.value[1:0] - 2'd1;
					col_d = 4'd0;
					pay1  = row_addr(cmd.value[1:0] - 2'd1);
				end
			end
			CMD_DISP_MODE: begin
				if (cmd.value <= MODE_MAX) begin
					n_one = 1'b1;
					pay1  = mode_code(cmd.value[2:0]);
				end
			end
			CMD_CLEAR_ALL: begin
				n_one = 1'b1;
				upd   = 1'b1;
				row_d = 2'd0;
				col_d = 4'd0;
				pay1  = INSTR_CLEAR;
			end
			CMD_EFFECT: begin
				if (cmd.value == EFF_SHIFT_RIGHT) begin
					n_one = 1'b1;
					pay1  = INSTR_SHR;
				end else if (cmd.value == EFF_SHIFT_LEFT) begin
					n_one = 1'b1;
					pay1  = INSTR_SHL;
				end else if (cmd.value == EFF_HIGHLIGHT) begin
					n_one = 1'b1;
					n_two = 1'b1;
					upd   = 1'b1;
					row_d = 2'd0;
					col_d = 4'd0;
					pay1  = INSTR_HOME;
					pay2  = INSTR_HILITE;
				end
			end
			CMD_RAW_INSTR: begin
				n_one = 1'b1;
			end
			default: begin
				n_one = 1'b0;
			end
		endcase
	end

	// second frame of an item goes out from the pending register
	always_comb begin
		if (pend_q) begin
			push             = ~q_full;
			push_job.is_data = 1'b0;
			push_job.payload = pend_payload_q;
			push_job.last    = 1'b1;
		end else begin
			push             = acc & n_one;
			push_job.is_data = data1;
			push_job.payload = pay1;
			push_job.last    = ~n_two;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q  <= 2'd0;
			col_q  <= 4'd0;
			pend_q <= 1'b0;
		end else begin
			if (acc && upd) begin
				row_q <= row_d;
				col_q <= col_d;
			end
			if (acc && n_two) begin
				pend_q <= 1'b1;
			end else if (pend_q && !q_full) begin
				pend_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc && n_two) begin
			pend_payload_q <= pay2;
		end
	end

endmodule

// ===== rtl/slcw_fifo.sv =====
// ----------------------------------------------------------------------------
// slcw_fifo: frame job queue
// Small queue between the decoder and the serializer.
// ----------------------------------------------------------------------------
module slcw_fifo (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  slcw_pkg::frame_job_t  push_job,
	output logic                  full,
	input  logic                  pop,
	output slcw_pkg::frame_job_t  pop_job,
	output logic                  empty
);
	import slcw_pkg::*;

	localparam int DEPTH = 4;
	localparam int PTR_W = $clog2(DEPTH);

	frame_job_t       mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == (PTR_W+1)'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push & ~full;
	assign do_pop  = pop & ~empty;
	assign pop_job = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== rtl/slcw_back.sv =====
// ----------------------------------------------------------------------------
// slcw_back: frame serializer
// Shifts each frame job out msb first, one bit word per cycle while ser_stall is low.
// ----------------------------------------------------------------------------
module slcw_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_empty,
	input  slcw_pkg::frame_job_t  q_job,
	output logic                  pop,
	output logic                  ser_valid,
	input  logic                  ser_stall,
	output slcw_pkg::ser_word_t   ser_word
);
	import slcw_pkg::*;

	localparam logic [BIT_CNT_W-1:0] LAST_BIT = BIT_CNT_W'(FRAME_BITS - 1);

	logic [FRAME_BITS-1:0] shift_q;
	logic [BIT_CNT_W-1:0]  cnt_q;
	logic                  busy_q;
	logic                  job_last_q;
	logic                  ovalid_q;
	ser_word_t             oword_q;
	logic                  out_load;
	logic                  frame_done;

	assign out_load   = busy_q & (~ovalid_q | ~ser_stall);
	assign frame_done = out_load & (cnt_q == LAST_BIT);
	assign pop        = ~q_empty & (~busy_q | frame_done);
	assign ser_valid  = ovalid_q;
	assign ser_word   = oword_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			cnt_q    <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (pop) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (frame_done) begin
				busy_q <= 1'b0;
				cnt_q  <= '0;
			end else if (out_load) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (out_load) begin
				ovalid_q <= 1'b1;
			end else if (!ser_stall) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			shift_q    <= {(q_job.is_data ? SYNC_DATA : SYNC_INSTR),
				q_job.payload[7:4], 4'd0, q_job.payload[3:0], 4'd0};
			job_last_q <= q_job.last;
		end else if (out_load) begin
			shift_q <= {shift_q[FRAME_BITS-2:0], 1'b0};
		end
		if (out_load) begin
			oword_q.sid_bit   <= shift_q[FRAME_BITS-1];
			oword_q.frame_end <= (cnt_q == LAST_BIT);
			oword_q.last      <= (cnt_q == LAST_BIT) & job_last_q;
		end
	end

endmodule

// ===== rtl/slcw_checker.sv =====
// ----------------------------------------------------------------------------
// slcw_checker: port level checks of the serial lcd command writer
// Frame framing and output handshake rules, bound to the top level.
// ----------------------------------------------------------------------------
module slcw_checker (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cmd_valid,
	input  logic                 cmd_stall,
	input  slcw_pkg::cmd_word_t  cmd_word,
	input  logic                 ser_valid,
	input  logic                 ser_stall,
	input  slcw_pkg::ser_word_t  ser_word
);
	import slcw_pkg::*;

	logic [BIT_CNT_W-1:0] bit_cnt_q;
	logic                 ser_acc;

	assign ser_acc = ser_valid & ~ser_stall;

	// position of the next accepted bit within its frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_cnt_q <= '0;
		end else if (ser_acc) begin
			if (ser_word.frame_end) begin
				bit_cnt_q <= '0;
			end else begin
				bit_cnt_q <= bit_cnt_q + 1'b1;
			end
		end
	end

	a_frame_len: assert property (@(posedge clk) disable iff (!arst_n)
		ser_acc |-> (ser_word.frame_end == (bit_cnt_q == BIT_CNT_W'(FRAME_BITS - 1))))
		else $error("frame_end not on the 24th bit");

	a_last_on_end: assert property (@(posedge clk) disable iff (!arst_n)
		ser_acc && ser_word.last |-> ser_word.frame_end)
		else $error("last outside a frame end");

	// sync byte always starts 1111_10x0
	a_sync_head: assert property (@(posedge clk) disable iff (!arst_n)
		ser_acc && (bit_cnt_q == '0) |-> ser_word.sid_bit)
		else $error("frame does not start with the sync pattern");

	a_ser_hold: assert property (@(posedge clk) disable iff (!arst_n)
		ser_valid && ser_stall |=> ser_valid && $stable(ser_word))
		else $error("stalled output word changed");

	a_cmd_hold: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_stall |=> cmd_valid && $stable(cmd_word))
		else $error("stalled command word changed");

endmodule

bind serial_lcd_command_writer_top slcw_checker u_slcw_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cmd_valid (cmd_valid),
	.cmd_stall (cmd_stall),
	.cmd_word  (cmd_word),
	.ser_valid (ser_valid),
	.ser_stall (ser_stall),
	.ser_word  (ser_word)
);
